// ===== rtl/tidsu_pkg.sv =====
// Shared types, codes and a helper function for the transparent item depth sorter.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package tidsu_pkg;

   localparam int CAPACITY  = 1024;
   localparam int ADDR_W    = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int NUM_KINDS = 6;
   localparam int KCNT_W    = 11;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_SORT  = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_END  = 2'd2
   } status_type;

   localparam logic [2:0] RANK_OTHER = 3'd6;

   // One stored item.
   typedef struct packed {
      logic [31:0] distance_sq;
      logic [31:0] batch_key;
      logic [2:0]  kind;
      logic [7:0]  sub_kind;
      logic [9:0]  payload_index;
   } entry_type;

   // Legacy category rank: the kind code for known kinds, otherwise the last rank.
   function automatic logic [2:0] kind_rank(input logic [2:0] kind);
      kind_rank = (kind < 3'(NUM_KINDS)) ? kind : RANK_OTHER;
   endfunction

endpackage

// ===== rtl/tidsu_store.sv =====
// Item store of the depth sorter: one write port and one registered read port.
// Depends on tidsu_pkg for the entry type and the store depth.
module tidsu_store (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [tidsu_pkg::ADDR_W-1:0] wr_addr,
   input  tidsu_pkg::entry_type         wr_data,
   input  logic [tidsu_pkg::ADDR_W-1:0] rd_addr,
   output tidsu_pkg::entry_type         rd_data
);

   tidsu_pkg::entry_type mem [tidsu_pkg::CAPACITY];
   tidsu_pkg::entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port with registered data.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tidsu_compare.sv =====
// Shared ordering comparator: true when item a must be drawn strictly before item b.
// Depends on tidsu_pkg for the entry type and the kind rank function.
module tidsu_compare (
   input  logic                 category_mode,
   input  tidsu_pkg::entry_type a,
   input  tidsu_pkg::entry_type b,
   output logic                 a_first
);

   logic [2:0] rank_a;
   logic [2:0] rank_b;

   assign rank_a = tidsu_pkg::kind_rank(a.kind);
   assign rank_b = tidsu_pkg::kind_rank(b.kind);

   // Lexicographic compare: rank (category mode), far to near, kind, batch, payload.
   always_comb begin
      if (category_mode && (rank_a != rank_b)) begin
         a_first = rank_a < rank_b;
      end else if (a.distance_sq != b.distance_sq) begin
         a_first = a.distance_sq > b.distance_sq;
      end else if (a.kind != b.kind) begin
         a_first = a.kind < b.kind;
      end else if (a.batch_key != b.batch_key) begin
         a_first = a.batch_key < b.batch_key;
      end else begin
         a_first = a.payload_index < b.payload_index;
      end
   end

endmodule

// ===== rtl/transparent_item_depth_sorter_unit.sv =====
// Top level of the transparent item depth sorter: command decode, sort sequencer, output.
// Depends on tidsu_pkg, tidsu_store and tidsu_compare.

// Clear and add items are done straight from the idle state; a read goes through a read
// state, set by the registered read port of the item store. A sort is a stable insertion
// sort run by a sequencer around one comparator and the single store port pair: it loads
// each item, shifts every front neighbor that the item beats one place back, then puts the
// item down in the freed slot. The store holds 1024 items and needs no clearing after
// reset. The result of each item sits in an output register, so the next item is taken
// while it drains.
module transparent_item_depth_sorter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_distance_sq,
   input  logic [2:0]  req_kind,
   input  logic [7:0]  req_sub_kind,
   input  logic [31:0] req_batch_key,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_out_distance_sq,
   output logic [2:0]  rsp_out_kind,
   output logic [7:0]  rsp_out_sub_kind,
   output logic [31:0] rsp_out_batch_key,
   output logic [9:0]  rsp_payload_index,
   output logic        rsp_last_item,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_category_major_mode
);

   localparam int AW = tidsu_pkg::ADDR_W;
   localparam int CW = tidsu_pkg::CNT_W;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_READ = 5'b00010,
      ST_LOAD = 5'b00100,
      ST_CMP  = 5'b01000,
      ST_PUT  = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic                 mode_ff;
   logic [CW-1:0]        item_count_ff, item_count_in;
   logic [CW-1:0]        read_ptr_ff, read_ptr_in;
   logic [CW-1:0]        i_ff, i_in;
   logic [CW-1:0]        j_ff, j_in;
   logic                 last_ff, last_in;
   tidsu_pkg::entry_type key_ff, key_in;
   logic [tidsu_pkg::KCNT_W-1:0] kcnt_ff [tidsu_pkg::NUM_KINDS];
   logic [tidsu_pkg::KCNT_W-1:0] kcnt_in [tidsu_pkg::NUM_KINDS];

   logic                 out_valid_ff, out_valid_in;
   tidsu_pkg::status_type out_status_ff, out_status_in;
   tidsu_pkg::entry_type out_entry_ff, out_entry_in;
   logic                 out_last_ff, out_last_in;

   logic                 accept;
   logic                 out_free;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   tidsu_pkg::entry_type wr_data;
   logic [AW-1:0]        rd_addr;
   tidsu_pkg::entry_type rd_data;
   logic                 a_first;
   logic [CW-1:0]        i_next;
   logic [CW-1:0]        j_dec;
   tidsu_pkg::entry_type add_entry;
   logic                 kind_known;

   tidsu_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tidsu_compare u_compare (
      .category_mode (mode_ff),
      .a             (key_ff),
      .b             (rd_data),
      .a_first       (a_first)
   );

   // Handshakes.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign i_next     = i_ff + CW'(1);
   assign j_dec      = j_ff - CW'(1);
   assign kind_known = req_kind < 3'(tidsu_pkg::NUM_KINDS);

   // The item as it would be stored by an add.
   always_comb begin
      add_entry.distance_sq   = req_distance_sq;
      add_entry.batch_key     = req_batch_key;
      add_entry.kind          = req_kind;
      add_entry.sub_kind      = req_sub_kind;
      add_entry.payload_index = kind_known ? kcnt_ff[req_kind][9:0] : 10'd0;
   end

   // Command decode and sort sequencer.
   always_comb begin
      state_in      = state_ff;
      item_count_in = item_count_ff;
      read_ptr_in   = read_ptr_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      last_in       = last_ff;
      key_in        = key_ff;
      kcnt_in       = kcnt_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_status_in = out_status_ff;
      out_entry_in  = out_entry_ff;
      out_last_in   = out_last_ff;
      wr_en         = 1'b0;
      wr_addr       = j_ff[AW-1:0];
      wr_data       = key_ff;
      rd_addr       = read_ptr_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_op == tidsu_pkg::OP_SORT) begin
               rd_addr = AW'(1);
            end
            if (accept) begin
               unique case (req_op)
                  tidsu_pkg::OP_CLEAR: begin
                     item_count_in = '0;
                     read_ptr_in   = '0;
                     for (int k = 0; k < tidsu_pkg::NUM_KINDS; k++) begin
                        kcnt_in[k] = '0;
                     end
                     out_valid_in  = 1'b1;
                     out_status_in = tidsu_pkg::STATUS_OK;
                     out_entry_in  = '0;
                     out_last_in   = 1'b0;
                  end
                  tidsu_pkg::OP_ADD: begin
                     out_valid_in = 1'b1;
                     out_last_in  = 1'b0;
                     if (item_count_ff >= CW'(tidsu_pkg::CAPACITY)) begin
                        out_status_in = tidsu_pkg::STATUS_FULL;
                        out_entry_in  = add_entry;
                        out_entry_in.payload_index = 10'd0;
                     end else begin
                        out_status_in = tidsu_pkg::STATUS_OK;
                        out_entry_in  = add_entry;
                        wr_en         = 1'b1;
                        wr_addr       = item_count_ff[AW-1:0];
                        wr_data       = add_entry;
                        item_count_in = item_count_ff + CW'(1);
                        if (kind_known) begin
                           kcnt_in[req_kind] = kcnt_ff[req_kind] + tidsu_pkg::KCNT_W'(1);
                        end
                     end
                  end
                  tidsu_pkg::OP_SORT: begin
                     if (item_count_ff <= CW'(1)) begin
                        read_ptr_in   = '0;
                        out_valid_in  = 1'b1;
                        out_status_in = tidsu_pkg::STATUS_OK;
                        out_entry_in  = '0;
                        out_last_in   = 1'b0;
                     end else begin
                        i_in     = CW'(1);
                        state_in = ST_LOAD;
                     end
                  end
                  default: begin
                     if (read_ptr_ff >= item_count_ff) begin
                        out_valid_in  = 1'b1;
                        out_status_in = tidsu_pkg::STATUS_END;
                        out_entry_in  = '0;
                        out_last_in   = 1'b0;
                     end else begin
                        last_in     = (read_ptr_ff + CW'(1)) == item_count_ff;
                        read_ptr_in = read_ptr_ff + CW'(1);
                        state_in    = ST_READ;
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            out_valid_in  = 1'b1;
            out_status_in = tidsu_pkg::STATUS_OK;
            out_entry_in  = rd_data;
            out_last_in   = last_ff;
            state_in      = ST_IDLE;
         end
         ST_LOAD: begin
            // Pick up item i and start comparing it with its neighbor in front.
            key_in   = rd_data;
            j_in     = i_ff;
            rd_addr  = AW'(i_ff - CW'(1));
            state_in = ST_CMP;
         end
         default: begin
            // ST_CMP shifts the front neighbor back while the held item beats it, else drops the held
            // item in its slot; ST_PUT drops the held item at the front of the store.
            if ((state_ff == ST_CMP) && a_first) begin
               wr_en   = 1'b1;
               wr_addr = j_ff[AW-1:0];
               wr_data = rd_data;
               j_in    = j_dec;
               rd_addr = AW'(j_ff - CW'(2));
               if (j_dec == '0) begin
                  state_in = ST_PUT;
               end
            end else begin
               wr_en   = 1'b1;
               wr_addr = j_ff[AW-1:0];
               wr_data = key_ff;
               i_in    = i_next;
               rd_addr = i_next[AW-1:0];
               if (i_next == item_count_ff) begin
                  read_ptr_in   = '0;
                  out_valid_in  = 1'b1;
                  out_status_in = tidsu_pkg::STATUS_OK;
                  out_entry_in  = '0;
                  out_last_in   = 1'b0;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= 1'b0;
         item_count_ff <= '0;
         read_ptr_ff   <= '0;
         out_valid_ff  <= 1'b0;
         for (int k = 0; k < tidsu_pkg::NUM_KINDS; k++) begin
            kcnt_ff[k] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         item_count_ff <= item_count_in;
         read_ptr_ff   <= read_ptr_in;
         out_valid_ff  <= out_valid_in;
         kcnt_ff       <= kcnt_in;
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_category_major_mode;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      j_ff          <= j_in;
      last_ff       <= last_in;
      key_ff        <= key_in;
      out_status_ff <= out_status_in;
      out_entry_ff  <= out_entry_in;
      out_last_ff   <= out_last_in;
   end

   // Result ports.
   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = out_status_ff;
   assign rsp_out_distance_sq = out_entry_ff.distance_sq;
   assign rsp_out_kind        = out_entry_ff.kind;
   assign rsp_out_sub_kind    = out_entry_ff.sub_kind;
   assign rsp_out_batch_key   = out_entry_ff.batch_key;
   assign rsp_payload_index   = out_entry_ff.payload_index;
   assign rsp_last_item       = out_last_ff;

   // The fill count never passes the store depth.
   assert property (@(posedge clock) disable iff (reset)
      item_count_ff <= CW'(tidsu_pkg::CAPACITY))
      else $error("item count beyond store depth");

   // The read pointer never runs past the filled part of the store.
   assert property (@(posedge clock) disable iff (reset)
      read_ptr_ff <= item_count_ff)
      else $error("read pointer beyond item count");

   // While comparing, the insertion slot lies inside the sorted prefix.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> ((j_ff != '0) && (j_ff <= i_ff) && (i_ff < item_count_ff)))
      else $error("insertion slot out of range");

   // No item is taken while the sequencer is busy.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !accept)
      else $error("item accepted while busy");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for transparent_item_depth_sorter_unit: a directed table, then
// random frames of adds, sorts and reads checked against a predictor of the sort order.
// Depends on tidsu_pkg and the RTL of the block.
module testbench;

   localparam int LIMIT_CYCLES = 600000;

   // One result as it leaves the block.
   typedef struct packed {
      tidsu_pkg::status_type status;
      logic [31:0] dsq;
      logic [2:0]  kind;
      logic [7:0]  sub;
      logic [31:0] key;
      logic [9:0]  pidx;
      logic        last;
   } result_type;

   // One row of the directed table.
   typedef struct {
      tidsu_pkg::op_type op;
      logic [31:0] dsq;
      logic [2:0]  kind;
      logic [7:0]  sub;
      logic [31:0] key;
      bit          typed;
      result_type  want;
   } row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_op = tidsu_pkg::OP_CLEAR;
   logic [31:0] req_distance_sq = 0;
   logic [2:0]  req_kind = 0;
   logic [7:0]  req_sub_kind = 0;
   logic [31:0] req_batch_key = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_out_distance_sq;
   logic [2:0]  rsp_out_kind;
   logic [7:0]  rsp_out_sub_kind;
   logic [31:0] rsp_out_batch_key;
   logic [9:0]  rsp_payload_index;
   logic        rsp_last_item;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic        csr_category_major_mode = 0;

   transparent_item_depth_sorter_unit dut (.*);

   always #1 clock = ~clock;

   // Predictor state: the store, counters and the sort mode register.
   tidsu_pkg::entry_type sorted_store[tidsu_pkg::CAPACITY];
   int          stored_count;
   int          read_ptr;
   logic [10:0] kind_count[tidsu_pkg::NUM_KINDS];
   logic        category_mode;

   result_type  pending_results[$];
   int          errors;
   int          items_sent;
   int          results_seen;
   int          cycles;
   int          stall_left;
   bit          quiet;

   function automatic logic [2:0] rank_of(logic [2:0] k);
      return (k < 3'd6) ? k : 3'd6;
   endfunction

   // True when entry a must be drawn strictly before entry b.
   function automatic bit drawn_first(tidsu_pkg::entry_type a, tidsu_pkg::entry_type b);
      if (category_mode && rank_of(a.kind) != rank_of(b.kind))
         return rank_of(a.kind) < rank_of(b.kind);
      if (a.distance_sq != b.distance_sq) return a.distance_sq > b.distance_sq;
      if (a.kind != b.kind) return a.kind < b.kind;
      if (a.batch_key != b.batch_key) return a.batch_key < b.batch_key;
      return a.payload_index < b.payload_index;
   endfunction

   // Applies one item to the predictor state and returns the result it causes.
   function automatic result_type sorter_result(tidsu_pkg::op_type op, logic [31:0] dsq,
         logic [2:0] kind, logic [7:0] sub, logic [31:0] key);
      result_type r;
      tidsu_pkg::entry_type e;
      int         j;
      r = '0;
      case (op)
         tidsu_pkg::OP_CLEAR: begin
            stored_count = 0;
            read_ptr = 0;
            foreach (kind_count[k]) kind_count[k] = 0;
         end
         tidsu_pkg::OP_ADD: begin
            r.dsq = dsq; r.kind = kind; r.sub = sub; r.key = key;
            if (stored_count >= tidsu_pkg::CAPACITY) begin
               r.status = tidsu_pkg::STATUS_FULL;
            end else begin
               if (kind < tidsu_pkg::NUM_KINDS) begin
                  r.pidx = kind_count[kind][9:0];
                  kind_count[kind] = kind_count[kind] + 11'd1;
               end
               sorted_store[stored_count] = '{dsq, key, kind, sub, r.pidx};
               stored_count++;
            end
         end
         tidsu_pkg::OP_SORT: begin
            // Stable insertion sort over the filled part of the store.
            for (int i = 1; i < stored_count; i++) begin
               j = i;
               while (j > 0 && drawn_first(sorted_store[j], sorted_store[j-1])) begin
                  e = sorted_store[j];
                  sorted_store[j] = sorted_store[j-1];
                  sorted_store[j-1] = e;
                  j--;
               end
            end
            read_ptr = 0;
         end
         default: begin
            if (read_ptr >= stored_count) begin
               r.status = tidsu_pkg::STATUS_END;
            end else begin
               e = sorted_store[read_ptr];
               r = '{tidsu_pkg::STATUS_OK, e.distance_sq, e.kind, e.sub_kind, e.batch_key,
                     e.payload_index, read_ptr + 1 == stored_count};
               read_ptr++;
            end
         end
      endcase
      return r;
   endfunction

   // Sends one item after a random gap and records what it must produce.
   task automatic send_item(tidsu_pkg::op_type op, logic [31:0] dsq, logic [2:0] kind,
         logic [7:0] sub, logic [31:0] key, bit typed = 0, result_type want = '0);
      int gap;
      result_type r;
      result_type expected;
      gap = quiet ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1;
      req_op = op;
      req_distance_sq = dsq;
      req_kind = kind;
      req_sub_kind = sub;
      req_batch_key = key;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      r = sorter_result(op, dsq, kind, sub, key);
      expected = typed ? want : r;
      pending_results = {pending_results, expected};
      items_sent++;
      @(negedge clock);
   endtask

   // Sends an item of the given operation with random contents in every field.
   task automatic send_noise(tidsu_pkg::op_type op);
      send_item(op, $urandom, 3'($urandom), 8'($urandom), $urandom);
   endtask

   // Holds the sender until every result is back, then lets the block settle.
   task automatic drain;
      req_valid = 0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_mode(logic mode);
      drain();
      csr_valid = 1;
      csr_category_major_mode = mode;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      category_mode = mode;
      @(negedge clock);
      csr_valid = 0;
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 3))
         0: return 32'hFFFF_FFFF;
         1: return $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   // One frame: clear, random adds and other operations, an optional early read, sort, reads.
   task automatic random_frame;
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 16);
      quiet = ($urandom_range(0, 3) == 0);
      send_noise(tidsu_pkg::OP_CLEAR);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_noise(tidsu_pkg::op_type'($urandom_range(0, 3)));
         else
            send_item(tidsu_pkg::OP_ADD, pick_word(), 3'($urandom_range(0, 7)),
                      8'($urandom), pick_word());
      end
      if ($urandom_range(0, 3) == 0) send_noise(tidsu_pkg::OP_READ);
      send_noise(tidsu_pkg::OP_SORT);
      repeat (n + $urandom_range(0, 2))
         send_noise(tidsu_pkg::OP_READ);
   endtask

   // Result check against the oldest expectation.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         stall_left <= quiet ? 0 : $urandom_range(0, 8);
         if (pending_results.size() == 0) begin
            $error("result arrived with no item outstanding");
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status != want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status); errors++;
            end
            if (rsp_out_distance_sq != want.dsq) begin
               $error("out_distance_sq: expected %h, got %h", want.dsq, rsp_out_distance_sq);
               errors++;
            end
            if (rsp_out_kind != want.kind) begin
               $error("out_kind: expected %0d, got %0d", want.kind, rsp_out_kind); errors++;
            end
            if (rsp_out_sub_kind != want.sub) begin
               $error("out_sub_kind: expected %h, got %h", want.sub, rsp_out_sub_kind); errors++;
            end
            if (rsp_out_batch_key != want.key) begin
               $error("out_batch_key: expected %h, got %h", want.key, rsp_out_batch_key);
               errors++;
            end
            if (rsp_payload_index != want.pidx) begin
               $error("payload_index: expected %0d, got %0d", want.pidx, rsp_payload_index);
               errors++;
            end
            if (rsp_last_item != want.last) begin
               $error("last_item: expected %0d, got %0d", want.last, rsp_last_item); errors++;
            end
         end
      end
   end

   // Receiver stalls for a drawn number of cycles after each result.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      row_type     rows[$];
      result_type  end_of_list;
      end_of_list = '{tidsu_pkg::STATUS_END, 0, 0, 0, 0, 0, 0};
      errors = 0; items_sent = 0; results_seen = 0; cycles = 0; stall_left = 0;
      quiet = 0;
      void'(sorter_result(tidsu_pkg::OP_CLEAR, 0, 0, 0, 0));
      category_mode = 0;

      // Directed table: extremes, read, sort and add, ties, unknown kinds, end of list.
      rows = '{
         '{tidsu_pkg::OP_READ, 0, 0, 0, 0, 1, end_of_list},
         '{tidsu_pkg::OP_SORT, 32'hFFFF_FFFF, 7, 8'hFF, 32'hFFFF_FFFF, 1, '0},
         '{tidsu_pkg::OP_ADD, 32'hFFFF_FFFF, 0, 8'hFF, 32'hFFFF_FFFF, 1,
           '{tidsu_pkg::STATUS_OK, 32'hFFFF_FFFF, 3'd0, 8'hFF, 32'hFFFF_FFFF, 10'd0, 1'b0}},
         '{tidsu_pkg::OP_ADD, 0, 5, 0, 0, 1,
           '{tidsu_pkg::STATUS_OK, 0, 3'd5, 0, 0, 10'd0, 1'b0}},
         '{tidsu_pkg::OP_ADD, 0, 0, 8'h5A, 0, 1,
           '{tidsu_pkg::STATUS_OK, 0, 3'd0, 8'h5A, 0, 10'd1, 1'b0}},
         '{tidsu_pkg::OP_ADD, 100, 6, 1, 7, 0, '0},
         '{tidsu_pkg::OP_ADD, 100, 7, 2, 7, 0, '0},
         '{tidsu_pkg::OP_ADD, 100, 2, 3, 5, 0, '0},
         '{tidsu_pkg::OP_ADD, 100, 2, 4, 3, 0, '0},
         '{tidsu_pkg::OP_ADD, 100, 1, 5, 9, 0, '0},
         '{tidsu_pkg::OP_ADD, 100, 2, 6, 3, 0, '0},
         '{tidsu_pkg::OP_ADD, 32'h3F80_0000, 3, 7, 1, 0, '0},
         '{tidsu_pkg::OP_ADD, 32'h3F80_0000, 4, 8, 1, 0, '0},
         '{tidsu_pkg::OP_READ, 0, 0, 0, 0, 0, '0},
         '{tidsu_pkg::OP_SORT, 0, 0, 0, 0, 0, '0}
      };
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;
      foreach (rows[i])
         send_item(rows[i].op, rows[i].dsq, rows[i].kind, rows[i].sub, rows[i].key,
                   rows[i].typed, rows[i].want);
      repeat (12) send_item(tidsu_pkg::OP_READ, 0, 0, 0, 0);
      send_item(tidsu_pkg::OP_READ, 0, 0, 0, 0, 1, end_of_list);
      send_item(tidsu_pkg::OP_CLEAR, 0, 0, 0, 0, 1, '0);
      send_item(tidsu_pkg::OP_READ, 0, 0, 0, 0, 1, end_of_list);

      // Same kind of frame again under category ordering, then random frames.
      write_mode(1);
      foreach (rows[i])
         if (rows[i].op == tidsu_pkg::OP_ADD)
            send_item(tidsu_pkg::OP_ADD, rows[i].dsq, rows[i].kind, rows[i].sub, rows[i].key);
      send_item(tidsu_pkg::OP_SORT, 0, 0, 0, 0);
      repeat (12) send_item(tidsu_pkg::OP_READ, 0, 0, 0, 0);
      repeat (2) random_frame();

      // Fill the store past capacity with nearly presorted distances so the sort stays short.
      write_mode(0);
      quiet = 0;
      send_item(tidsu_pkg::OP_CLEAR, 0, 0, 0, 0);
      for (int i = 0; i < tidsu_pkg::CAPACITY + 3; i++)
         send_item(tidsu_pkg::OP_ADD,
                   32'(((2000 - i) << 20) | $urandom_range(0, 32'hF_FFFF)),
                   3'($urandom_range(0, 7)), 8'($urandom), $urandom);
      send_item(tidsu_pkg::OP_SORT, 0, 0, 0, 0);
      repeat (8) send_item(tidsu_pkg::OP_READ, 0, 0, 0, 0);
      drain();

      for (int f = 0; f < 2; f++) begin
         if (f == 1) write_mode(1);
         random_frame();
      end
      write_mode(0);
      random_frame();

      drain();
      repeat (20) @(posedge clock);
      $display("Ran %0d items (%0d results) over both sort modes, including a full store.",
               items_sent, results_seen);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
